// ===== hdl/ffha_pkg.sv =====
// Shared types, codes and defaults of the first-fit heap allocator.
// No dependencies; every other file takes names from here by scope.
`timescale 1ns / 1ps

package ffha_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int HEADER_BYTES_DEF = 16;
    localparam int DATA_W           = 32;
    localparam int CFG_IDX_W        = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BYTES = 1'd1;

    typedef enum logic [1:0] {
        OP_INIT    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NO_FIT      = 2'd1,
        ST_BAD_RELEASE = 2'd2,
        ST_TOO_SMALL   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_WALK,
        S_SPLIT_CHK,
        S_GRAB,
        S_SPLIT_NEW,
        S_SPLIT_OLD,
        S_ALLOC_FIN,
        S_REL_CLR,
        S_REL_PREV,
        S_REL_NXT_RD,
        S_REL_NEXT,
        S_DONE
    } state_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_INIT,
        CMD_FAIL,
        CMD_STEP,
        CMD_HIT,
        CMD_SCAN_START,
        CMD_SCAN_INC,
        CMD_GRAB,
        CMD_SPLIT_NEW,
        CMD_SPLIT_OLD,
        CMD_ALLOC_FIN,
        CMD_REL_CLR,
        CMD_MRG_PREV,
        CMD_RD_NEXT,
        CMD_MRG_NEXT
    } cmd_t;

    typedef struct packed {
        cmd_t cmd;
        logic push;
    } ctl_t;

    typedef struct packed {
        op_t  op;
        logic cur_nil;
        logic hit;
        logic can_split;
        logic scan_end;
        logic scan_free;
        logic prev_merge;
        logic next_merge;
        logic out_busy;
    } dp_sts_t;

endpackage

// ===== hdl/ffha_req_if.sv =====
// Request channel of the allocator: valid/ready plus op and operands.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

interface ffha_req_if;
    logic                          valid;
    logic                          ready;
    ffha_pkg::op_t                 op;
    logic [ffha_pkg::DATA_W-1:0]   request_size;
    logic [ffha_pkg::DATA_W-1:0]   release_address;

    modport source (output valid, output op, output request_size,
                    output release_address, input ready);
    modport sink   (input valid, input op, input request_size,
                    input release_address, output ready);
endinterface

// ===== hdl/ffha_rsp_if.sv =====
// Response channel of the allocator: valid/ready plus address and status.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

interface ffha_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ffha_pkg::DATA_W-1:0]   result_address;
    ffha_pkg::status_t             status;

    modport source (output valid, output result_address, output status, input ready);
    modport sink   (input valid, input result_address, input status, output ready);
endinterface

// ===== hdl/ffha_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and data.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

interface ffha_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ffha_pkg::CFG_IDX_W-1:0]  index;
    logic [ffha_pkg::DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/ffha_ctrl.sv =====
// Allocator controller: state machine that sequences the datapath.
// Depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  ffha_pkg::op_t     in_op,
    output logic              in_ready,
    input  ffha_pkg::dp_sts_t sts,
    output ffha_pkg::ctl_t    ctl
);

    ffha_pkg::state_t state_reg;
    ffha_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffha_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl.cmd    = ffha_pkg::CMD_NONE;
        ctl.push   = 1'b0;
        in_ready   = (state_reg == ffha_pkg::S_IDLE);
        unique case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    ctl.cmd = ffha_pkg::CMD_LOAD;
                    unique case (in_op)
                        ffha_pkg::OP_INIT:    state_next = ffha_pkg::S_INIT;
                        ffha_pkg::OP_ALLOC:   state_next = ffha_pkg::S_WALK;
                        ffha_pkg::OP_RELEASE: state_next = ffha_pkg::S_WALK;
                        ffha_pkg::OP_NONE:    state_next = ffha_pkg::S_DONE;
                    endcase
                end
            end
            ffha_pkg::S_INIT:
            begin
                ctl.cmd    = ffha_pkg::CMD_INIT;
                state_next = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_WALK:
            begin
                priority if (sts.cur_nil)
                begin
                    ctl.cmd    = ffha_pkg::CMD_FAIL;
                    state_next = ffha_pkg::S_DONE;
                end
                else if (sts.hit)
                begin
                    ctl.cmd    = ffha_pkg::CMD_HIT;
                    state_next = (sts.op == ffha_pkg::OP_ALLOC) ? ffha_pkg::S_SPLIT_CHK
                                                                : ffha_pkg::S_REL_CLR;
                end
                else
                begin
                    ctl.cmd = ffha_pkg::CMD_STEP;
                end
            end
            ffha_pkg::S_SPLIT_CHK:
            begin
                if (sts.can_split)
                begin
                    ctl.cmd    = ffha_pkg::CMD_SCAN_START;
                    state_next = ffha_pkg::S_GRAB;
                end
                else
                begin
                    state_next = ffha_pkg::S_ALLOC_FIN;
                end
            end
            ffha_pkg::S_GRAB:
            begin
                priority if (sts.scan_end)
                begin
                    state_next = ffha_pkg::S_ALLOC_FIN;
                end
                else if (sts.scan_free)
                begin
                    ctl.cmd    = ffha_pkg::CMD_GRAB;
                    state_next = ffha_pkg::S_SPLIT_NEW;
                end
                else
                begin
                    ctl.cmd = ffha_pkg::CMD_SCAN_INC;
                end
            end
            ffha_pkg::S_SPLIT_NEW:
            begin
                ctl.cmd    = ffha_pkg::CMD_SPLIT_NEW;
                state_next = ffha_pkg::S_SPLIT_OLD;
            end
            ffha_pkg::S_SPLIT_OLD:
            begin
                ctl.cmd    = ffha_pkg::CMD_SPLIT_OLD;
                state_next = ffha_pkg::S_ALLOC_FIN;
            end
            ffha_pkg::S_ALLOC_FIN:
            begin
                ctl.cmd    = ffha_pkg::CMD_ALLOC_FIN;
                state_next = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_REL_CLR:
            begin
                ctl.cmd    = ffha_pkg::CMD_REL_CLR;
                state_next = sts.prev_merge ? ffha_pkg::S_REL_PREV : ffha_pkg::S_REL_NXT_RD;
            end
            ffha_pkg::S_REL_PREV:
            begin
                ctl.cmd    = ffha_pkg::CMD_MRG_PREV;
                state_next = ffha_pkg::S_REL_NXT_RD;
            end
            ffha_pkg::S_REL_NXT_RD:
            begin
                ctl.cmd    = ffha_pkg::CMD_RD_NEXT;
                state_next = sts.next_merge ? ffha_pkg::S_REL_NEXT : ffha_pkg::S_DONE;
            end
            ffha_pkg::S_REL_NEXT:
            begin
                ctl.cmd    = ffha_pkg::CMD_MRG_NEXT;
                state_next = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    ctl.push   = 1'b1;
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/ffha_dp.sv =====
// Allocator datapath: segment table memories, used/in-use bits, list walk
// registers, configuration and response registers. Depends on ffha_pkg.
`timescale 1ns / 1ps

module ffha_dp #(
    parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ffha_pkg::ctl_t              ctl,
    output ffha_pkg::dp_sts_t           sts,
    input  ffha_pkg::op_t               in_op,
    input  logic [ffha_pkg::DATA_W-1:0] in_request_size,
    input  logic [ffha_pkg::DATA_W-1:0] in_release_address,
    ffha_cfg_if.sink                    cfg,
    ffha_rsp_if.source                  rsp
);

    localparam int AW = $clog2(MAX_SEGMENTS);
    localparam int IW = $clog2(MAX_SEGMENTS + 1);
    localparam int DW = ffha_pkg::DATA_W;
    localparam logic [IW-1:0]   NIL   = IW'(MAX_SEGMENTS);
    localparam logic [DW-1:0]   HDR   = DW'(HEADER_BYTES);
    localparam logic [DW+1:0]   HDR_X = (DW+2)'(HEADER_BYTES);

    logic [DW-1:0] start_mem [MAX_SEGMENTS];
    logic [DW-1:0] size_mem  [MAX_SEGMENTS];
    logic [IW-1:0] next_mem  [MAX_SEGMENTS];
    logic [IW-1:0] prev_mem  [MAX_SEGMENTS];

    logic [DW-1:0] rd_start_reg, rd_size_reg;
    logic [IW-1:0] rd_next_reg, rd_prev_reg;
    logic [IW-1:0] rd_idx;

    logic          st_we, sz_we, nx_we, pv_we;
    logic [IW-1:0] st_wa, sz_wa, nx_wa, pv_wa;
    logic [DW-1:0] st_wd, sz_wd;
    logic [IW-1:0] nx_wd, pv_wd;

    logic [DW-1:0]           base_reg, bytes_reg;
    logic [MAX_SEGMENTS-1:0] used_reg, used_next;
    logic [MAX_SEGMENTS-1:0] inuse_reg, inuse_next;
    logic [IW-1:0]           head_reg, head_next;
    ffha_pkg::op_t           op_reg, op_next;
    logic [DW-1:0]           req_reg, req_next;
    logic [DW-1:0]           rel_reg, rel_next;
    logic [IW-1:0]           cur_reg, cur_next;
    logic [IW-1:0]           fidx_reg, fidx_next;
    logic [IW-1:0]           eidx_reg, eidx_next;
    logic [IW-1:0]           scan_reg, scan_next;
    logic [DW-1:0]           ent_start_reg, ent_start_next;
    logic [DW-1:0]           ent_size_reg, ent_size_next;
    logic [IW-1:0]           ent_next_reg, ent_next_next;
    logic [IW-1:0]           ent_prev_reg, ent_prev_next;
    logic [DW-1:0]           res_addr_reg, res_addr_next;
    ffha_pkg::status_t       res_status_reg, res_status_next;
    logic                    out_valid_reg, out_valid_next;
    logic [DW-1:0]           out_addr_reg, out_addr_next;
    ffha_pkg::status_t       out_status_reg, out_status_next;
    logic [DW-1:0]           merged_prev, merged_next;

    assign merged_prev = rd_size_reg + ent_size_reg + HDR;
    assign merged_next = ent_size_reg + rd_size_reg + HDR;

    assign cfg.ready          = 1'b1;
    assign rsp.valid          = out_valid_reg;
    assign rsp.result_address = out_addr_reg;
    assign rsp.status         = out_status_reg;

    assign sts.op         = op_reg;
    assign sts.cur_nil    = (cur_reg == NIL);
    assign sts.hit        = (op_reg == ffha_pkg::OP_ALLOC)
                          ? (!used_reg[cur_reg[AW-1:0]] && (rd_size_reg > req_reg))
                          : ((rd_start_reg + HDR) == rel_reg);
    assign sts.can_split  = ({2'b00, ent_size_reg} >= ({2'b00, req_reg} + HDR_X + (DW+2)'(1)));
    assign sts.scan_end   = (scan_reg == NIL);
    assign sts.scan_free  = !inuse_reg[scan_reg[AW-1:0]];
    assign sts.prev_merge = (ent_prev_reg != NIL) && !used_reg[ent_prev_reg[AW-1:0]];
    assign sts.next_merge = (ent_next_reg != NIL) && !used_reg[ent_next_reg[AW-1:0]];
    assign sts.out_busy   = out_valid_reg && !rsp.ready;

    always_comb
    begin
        rd_idx          = cur_reg;
        st_we = 1'b0; st_wa = '0; st_wd = '0;
        sz_we = 1'b0; sz_wa = '0; sz_wd = '0;
        nx_we = 1'b0; nx_wa = '0; nx_wd = '0;
        pv_we = 1'b0; pv_wa = '0; pv_wd = '0;
        used_next       = used_reg;
        inuse_next      = inuse_reg;
        head_next       = head_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        rel_next        = rel_reg;
        cur_next        = cur_reg;
        fidx_next       = fidx_reg;
        eidx_next       = eidx_reg;
        scan_next       = scan_reg;
        ent_start_next  = ent_start_reg;
        ent_size_next   = ent_size_reg;
        ent_next_next   = ent_next_reg;
        ent_prev_next   = ent_prev_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;

        if (ctl.push)
        begin
            out_valid_next  = 1'b1;
            out_addr_next   = res_addr_reg;
            out_status_next = res_status_reg;
        end

        unique case (ctl.cmd)
            ffha_pkg::CMD_NONE:
            begin
            end
            ffha_pkg::CMD_LOAD:
            begin
                op_next         = in_op;
                req_next        = in_request_size;
                rel_next        = in_release_address;
                cur_next        = head_reg;
                rd_idx          = head_reg;
                res_addr_next   = '0;
                res_status_next = ffha_pkg::ST_OK;
            end
            ffha_pkg::CMD_INIT:
            begin
                used_next  = '0;
                inuse_next = '0;
                if (bytes_reg < HDR)
                begin
                    head_next       = NIL;
                    res_status_next = ffha_pkg::ST_TOO_SMALL;
                end
                else
                begin
                    head_next     = '0;
                    inuse_next[0] = 1'b1;
                    st_we = 1'b1; st_wa = '0; st_wd = base_reg;
                    sz_we = 1'b1; sz_wa = '0; sz_wd = bytes_reg - HDR;
                    nx_we = 1'b1; nx_wa = '0; nx_wd = NIL;
                    pv_we = 1'b1; pv_wa = '0; pv_wd = NIL;
                end
            end
            ffha_pkg::CMD_FAIL:
            begin
                res_status_next = (op_reg == ffha_pkg::OP_ALLOC) ? ffha_pkg::ST_NO_FIT
                                                                 : ffha_pkg::ST_BAD_RELEASE;
            end
            ffha_pkg::CMD_STEP:
            begin
                cur_next = rd_next_reg;
                rd_idx   = rd_next_reg;
            end
            ffha_pkg::CMD_HIT:
            begin
                fidx_next      = cur_reg;
                ent_start_next = rd_start_reg;
                ent_size_next  = rd_size_reg;
                ent_next_next  = rd_next_reg;
                ent_prev_next  = rd_prev_reg;
            end
            ffha_pkg::CMD_SCAN_START:
            begin
                scan_next = '0;
            end
            ffha_pkg::CMD_SCAN_INC:
            begin
                scan_next = scan_reg + IW'(1);
            end
            ffha_pkg::CMD_GRAB:
            begin
                eidx_next                     = scan_reg;
                inuse_next[scan_reg[AW-1:0]]  = 1'b1;
            end
            ffha_pkg::CMD_SPLIT_NEW:
            begin
                st_we = 1'b1; st_wa = eidx_reg; st_wd = ent_start_reg + HDR + req_reg;
                sz_we = 1'b1; sz_wa = eidx_reg; sz_wd = ent_size_reg - req_reg - HDR;
                nx_we = 1'b1; nx_wa = eidx_reg; nx_wd = ent_next_reg;
                pv_we = 1'b1; pv_wa = eidx_reg; pv_wd = fidx_reg;
            end
            ffha_pkg::CMD_SPLIT_OLD:
            begin
                sz_we = 1'b1; sz_wa = fidx_reg; sz_wd = req_reg;
                nx_we = 1'b1; nx_wa = fidx_reg; nx_wd = eidx_reg;
                pv_we = (ent_next_reg != NIL); pv_wa = ent_next_reg; pv_wd = eidx_reg;
            end
            ffha_pkg::CMD_ALLOC_FIN:
            begin
                used_next[fidx_reg[AW-1:0]] = 1'b1;
                res_addr_next               = ent_start_reg + HDR;
            end
            ffha_pkg::CMD_REL_CLR:
            begin
                used_next[fidx_reg[AW-1:0]] = 1'b0;
                rd_idx                      = ent_prev_reg;
            end
            ffha_pkg::CMD_MRG_PREV:
            begin
                nx_we = 1'b1; nx_wa = ent_prev_reg; nx_wd = ent_next_reg;
                sz_we = 1'b1; sz_wa = ent_prev_reg; sz_wd = merged_prev;
                pv_we = (ent_next_reg != NIL); pv_wa = ent_next_reg; pv_wd = ent_prev_reg;
                inuse_next[fidx_reg[AW-1:0]] = 1'b0;
                ent_start_next = rd_start_reg;
                ent_size_next  = merged_prev;
                ent_prev_next  = rd_prev_reg;
                fidx_next      = ent_prev_reg;
            end
            ffha_pkg::CMD_RD_NEXT:
            begin
                rd_idx = ent_next_reg;
            end
            ffha_pkg::CMD_MRG_NEXT:
            begin
                sz_we = 1'b1; sz_wa = fidx_reg; sz_wd = merged_next;
                nx_we = 1'b1; nx_wa = fidx_reg; nx_wd = rd_next_reg;
                pv_we = (rd_next_reg != NIL); pv_wa = rd_next_reg; pv_wd = fidx_reg;
                inuse_next[ent_next_reg[AW-1:0]] = 1'b0;
                used_next[ent_next_reg[AW-1:0]]  = 1'b0;
                ent_size_next = merged_next;
                ent_next_next = rd_next_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            start_mem[st_wa[AW-1:0]] <= st_wd;
        end
        if (sz_we)
        begin
            size_mem[sz_wa[AW-1:0]] <= sz_wd;
        end
        if (nx_we)
        begin
            next_mem[nx_wa[AW-1:0]] <= nx_wd;
        end
        if (pv_we)
        begin
            prev_mem[pv_wa[AW-1:0]] <= pv_wd;
        end
        rd_start_reg <= start_mem[rd_idx[AW-1:0]];
        rd_size_reg  <= size_mem[rd_idx[AW-1:0]];
        rd_next_reg  <= next_mem[rd_idx[AW-1:0]];
        rd_prev_reg  <= prev_mem[rd_idx[AW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg      <= '0;
            bytes_reg     <= '0;
            used_reg      <= '0;
            inuse_reg     <= '0;
            head_reg      <= NIL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                unique case (cfg.index)
                    ffha_pkg::CFG_HEAP_BASE:  base_reg  <= cfg.data;
                    ffha_pkg::CFG_HEAP_BYTES: bytes_reg <= cfg.data;
                endcase
            end
            used_reg      <= used_next;
            inuse_reg     <= inuse_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        req_reg        <= req_next;
        rel_reg        <= rel_next;
        cur_reg        <= cur_next;
        fidx_reg       <= fidx_next;
        eidx_reg       <= eidx_next;
        scan_reg       <= scan_next;
        ent_start_reg  <= ent_start_next;
        ent_size_reg   <= ent_size_next;
        ent_next_reg   <= ent_next_next;
        ent_prev_reg   <= ent_prev_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

endmodule

// ===== hdl/first_fit_heap_allocator.sv =====
// Allocate walks the segment list, then may scan the entry table and split; release
// walks the list and may merge with free neighbours; init and unknown ops do neither.
// Throughput: one transaction at a time; the list walk reads one segment per
// cycle from the table memories.
// Reset: asynchronous, active low; empties the heap and clears heap_base/heap_bytes.
// Depends on ffha_pkg, the channel interfaces, ffha_ctrl and ffha_dp.
`timescale 1ns / 1ps

module first_fit_heap_allocator #(
    parameter int MAX_SEGMENTS = ffha_pkg::MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
    input logic      clk,
    input logic      rst_n,
    ffha_req_if.sink   req,
    ffha_rsp_if.source rsp,
    ffha_cfg_if.sink   cfg
);

    ffha_pkg::ctl_t    ctl;
    ffha_pkg::dp_sts_t sts;

    ffha_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_op    (req.op),
        .in_ready (req.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    ffha_dp #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (ctl),
        .sts                (sts),
        .in_op              (req.op),
        .in_request_size    (req.request_size),
        .in_release_address (req.release_address),
        .cfg                (cfg),
        .rsp                (rsp)
    );

endmodule

// ===== hdl/ffha_checker.sv =====
// Port-level checks of the allocator and their bind to the top level.
// Depends on ffha_pkg and first_fit_heap_allocator.
`timescale 1ns / 1ps

module ffha_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        req_valid,
    input logic                        req_ready,
    input logic                        rsp_valid,
    input logic                        rsp_ready,
    input logic [ffha_pkg::DATA_W-1:0] rsp_addr,
    input ffha_pkg::status_t           rsp_status
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transaction");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_addr) && $stable(rsp_status))
        else $error("response payload changed while stalled");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != ffha_pkg::ST_OK) |-> (rsp_addr == '0))
        else $error("failed response carries an address");

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in flight");

endmodule

bind first_fit_heap_allocator ffha_checker u_ffha_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_addr   (rsp.result_address),
    .rsp_status (rsp.status)
);
